// ===== sv/tilt_direction_classifier_core_macros.svh =====
// ----------------------------------------------------------------------------
// Tilt direction classifier assertion macros
// Concurrent assertion shorthands clocked on clock and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef TILT_DIRECTION_CLASSIFIER_CORE_MACROS_SVH
`define TILT_DIRECTION_CLASSIFIER_CORE_MACROS_SVH

// Check a consequent in the same cycle as its antecedent.
`define TDC_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("tdc assertion failed (same cycle)");

// Check a consequent in the cycle after its antecedent.
`define TDC_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("tdc assertion failed (next cycle)");

`endif

// ===== sv/tdc_pkg.sv =====
// ----------------------------------------------------------------------------
// Tilt direction classifier package
// Direction codes, register indexes, reset values and shared structs.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tdc_pkg;

   typedef enum logic [3:0] {
      DIR_NONE       = 4'd0,
      DIR_UP         = 4'd1,
      DIR_DOWN       = 4'd2,
      DIR_LEFT       = 4'd3,
      DIR_RIGHT      = 4'd4,
      DIR_UP_LEFT    = 4'd5,
      DIR_UP_RIGHT   = 4'd6,
      DIR_DOWN_LEFT  = 4'd7,
      DIR_DOWN_RIGHT = 4'd8
   } dir_type;

   localparam int unsigned CSR_INDEX_W = 3;
   localparam int unsigned CSR_DATA_W  = 16;

   typedef logic [CSR_INDEX_W-1:0] csr_index_type;

   localparam csr_index_type CSR_ENTER_THRESHOLD  = 3'd0;
   localparam csr_index_type CSR_EXIT_THRESHOLD   = 3'd1;
   localparam csr_index_type CSR_REPEAT_SAMPLES   = 3'd2;
   localparam csr_index_type CSR_SAMPLE_PERIOD_MS = 3'd3;
   localparam csr_index_type CSR_OFFSET_X         = 3'd4;
   localparam csr_index_type CSR_OFFSET_Y         = 3'd5;

   localparam logic [15:0] RST_ENTER_THRESHOLD  = 16'd4200;
   localparam logic [15:0] RST_EXIT_THRESHOLD   = 16'd2200;
   localparam logic [7:0]  RST_REPEAT_SAMPLES   = 8'd0;
   localparam logic [15:0] RST_SAMPLE_PERIOD_MS = 16'd50;

   // Classification settings handed to the classifier.
   typedef struct packed {
      logic        [15:0] enter_threshold;
      logic        [15:0] exit_threshold;
      logic signed [15:0] offset_x;
      logic signed [15:0] offset_y;
   } tdc_cfg_type;

   // Classifier verdict for one sample.
   typedef struct packed {
      dir_type dir;
      logic    release_hold;
   } tdc_class_type;

endpackage

// ===== sv/tdc_if.sv =====
// ----------------------------------------------------------------------------
// Tilt direction classifier channel interfaces
// Valid/ready channels for sample requests and direction responses.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface tdc_req_if;
   logic               valid;
   logic               ready;
   logic        [31:0] now_ms;
   logic signed [15:0] raw_x;
   logic signed [15:0] raw_y;

   modport source (output valid, now_ms, raw_x, raw_y, input ready);
   modport sink   (input valid, now_ms, raw_x, raw_y, output ready);
endinterface

interface tdc_rsp_if;
   logic       valid;
   logic       ready;
   logic [3:0] direction;
   logic       sampled;

   modport source (output valid, direction, sampled, input ready);
   modport sink   (input valid, direction, sampled, output ready);
endinterface

// ===== sv/tilt_direction_classifier_core.sv =====
// ----------------------------------------------------------------------------
// Tilt direction classifier core
// Period-gates timestamped X/Y accelerometer samples and reports tilt
// directions with exit hysteresis and repeat suppression.
// ----------------------------------------------------------------------------
//  channel  | direction | contents
//  ---------+-----------+-----------------------------------------------
//  req_ch   | in        | now_ms[31:0], raw_x[15:0] s, raw_y[15:0] s
//  rsp_ch   | out       | direction[3:0], sampled
//  csr_*    | in        | csr_we, csr_index[2:0], csr_wdata[15:0]
//
//  One transaction per clock sustained while the receiver is ready. A request
//  accepted sits in the input register, then moves to the result register
//  (response valid from then on) and completes as a response transaction once taken.
//  Held direction, repeat count and last accept time update when a sample
//  leaves the input register, so each sample sees its predecessor's state.
//  Synchronous active-high reset clears state and loads register defaults.
//  A stalled response holds the result register; the input register keeps
//  accepting as long as it can drain into the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "tilt_direction_classifier_core_macros.svh"

module tilt_direction_classifier_core
   import tdc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   tdc_req_if.sink               req_ch,
   tdc_rsp_if.source             rsp_ch,
   input  logic                  csr_we,
   input  csr_index_type         csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   // Configuration registers
   logic        [15:0] enter_threshold_ff;
   logic        [15:0] exit_threshold_ff;
   logic        [7:0]  repeat_samples_ff;
   logic        [15:0] sample_period_ff;
   logic signed [15:0] offset_x_ff;
   logic signed [15:0] offset_y_ff;

   // Input register
   logic               s1_valid_ff;
   logic        [31:0] s1_now_ff;
   logic signed [15:0] s1_raw_x_ff;
   logic signed [15:0] s1_raw_y_ff;

   // Result register
   logic               out_valid_ff;
   dir_type            out_dir_ff;
   logic               out_sampled_ff;

   // Classifier state
   dir_type            held_ff;
   dir_type            held_in;
   logic        [7:0]  repeat_ff;
   logic        [7:0]  repeat_in;
   logic        [31:0] last_time_ff;

   tdc_cfg_type        cfg;
   tdc_class_type      verdict;
   logic               advance;
   logic               req_fire;
   logic        [31:0] elapsed;
   logic               skip;
   dir_type            res_dir;

   // Advance when the result register is empty or being drained this cycle
   assign advance  = s1_valid_ff && (!out_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !s1_valid_ff || advance;
   assign req_fire = req_ch.valid && req_ch.ready;

   assign rsp_ch.valid     = out_valid_ff;
   assign rsp_ch.direction = out_dir_ff;
   assign rsp_ch.sampled   = out_sampled_ff;

   // Configuration writes; drop writes to unknown indexes
   always_ff @(posedge clock) begin
      if (reset) begin
         enter_threshold_ff <= RST_ENTER_THRESHOLD;
         exit_threshold_ff  <= RST_EXIT_THRESHOLD;
         repeat_samples_ff  <= RST_REPEAT_SAMPLES;
         sample_period_ff   <= RST_SAMPLE_PERIOD_MS;
         offset_x_ff        <= '0;
         offset_y_ff        <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_ENTER_THRESHOLD:  enter_threshold_ff <= csr_wdata;
            CSR_EXIT_THRESHOLD:   exit_threshold_ff  <= csr_wdata;
            CSR_REPEAT_SAMPLES:   repeat_samples_ff  <= csr_wdata[7:0];
            CSR_SAMPLE_PERIOD_MS: sample_period_ff   <= csr_wdata;
            CSR_OFFSET_X:         offset_x_ff        <= signed'(csr_wdata);
            CSR_OFFSET_Y:         offset_y_ff        <= signed'(csr_wdata);
            default: ;
         endcase
      end
   end

   assign cfg.enter_threshold = enter_threshold_ff;
   assign cfg.exit_threshold  = exit_threshold_ff;
   assign cfg.offset_x        = offset_x_ff;
   assign cfg.offset_y        = offset_y_ff;

   tdc_classify u_classify (
      .cfg     (cfg),
      .raw_x   (s1_raw_x_ff),
      .raw_y   (s1_raw_y_ff),
      .verdict (verdict)
   );

   // Period gate: a zero last time means no sample yet
   assign elapsed = s1_now_ff - last_time_ff;
   assign skip    = (last_time_ff != 32'd0) && (elapsed < 32'(sample_period_ff));

   // Hysteresis and repeat countdown
   always_comb begin
      held_in   = held_ff;
      repeat_in = repeat_ff;
      res_dir   = DIR_NONE;
      priority if (skip) begin
         // skipped sample leaves the state alone
      end else if (verdict.release_hold) begin
         held_in   = DIR_NONE;
         repeat_in = 8'd0;
      end else if (verdict.dir != DIR_NONE) begin
         priority if (verdict.dir != held_ff) begin
            held_in   = verdict.dir;
            repeat_in = repeat_samples_ff;
            res_dir   = verdict.dir;
         end else if (repeat_ff != 8'd0) begin
            repeat_in = repeat_ff - 8'd1;
         end else begin
            repeat_in = repeat_samples_ff;
            res_dir   = verdict.dir;
         end
      end
   end

   // Input register: hold while the result side is stalled
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ch.ready) begin
         s1_valid_ff <= req_ch.valid;
      end
      if (req_fire) begin
         s1_now_ff   <= req_ch.now_ms;
         s1_raw_x_ff <= req_ch.raw_x;
         s1_raw_y_ff <= req_ch.raw_y;
      end
   end

   // Result register and classifier state
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         held_ff      <= DIR_NONE;
         repeat_ff    <= 8'd0;
         last_time_ff <= 32'd0;
      end else begin
         if (advance) begin
            out_valid_ff <= 1'b1;
            held_ff      <= held_in;
            repeat_ff    <= repeat_in;
            if (!skip) begin
               last_time_ff <= s1_now_ff;
            end
         end else if (rsp_ch.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
      if (advance) begin
         out_dir_ff     <= res_dir;
         out_sampled_ff <= !skip;
      end
   end

   // A reported direction becomes the held direction
   `TDC_ASSERT_NEXT(a_report_holds, advance && (res_dir != DIR_NONE), held_ff == $past(res_dir))
   // A skipped sample changes neither the hold nor the countdown
   `TDC_ASSERT_NEXT(a_skip_keeps, advance && skip, $stable(held_ff) && $stable(repeat_ff))
   // A skipped sample leaves the last accept time alone
   `TDC_ASSERT_NEXT(a_skip_keeps_time, advance && skip, $stable(last_time_ff))
   // A skipped response never carries a direction
   `TDC_ASSERT_NOW(a_skip_none, out_valid_ff && !out_sampled_ff, out_dir_ff == DIR_NONE)
   // An accepted request is in the input register next cycle
   `TDC_ASSERT_NEXT(a_req_lands, req_fire, s1_valid_ff)

endmodule

// ===== sv/tdc_classify.sv =====
// ----------------------------------------------------------------------------
// Tilt direction classifier - sample classification
// Removes offsets, takes magnitudes and maps them to a direction code and a release flag.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tdc_classify
   import tdc_pkg::*;
(
   input  tdc_cfg_type        cfg,
   input  logic signed [15:0] raw_x,
   input  logic signed [15:0] raw_y,
   output tdc_class_type      verdict
);

   logic signed [16:0] ax;
   logic signed [16:0] ay;
   logic        [16:0] ax_abs;
   logic        [16:0] ay_abs;
   logic        [15:0] mx;
   logic        [15:0] my;
   logic               right;
   logic               down;
   logic               x_tilt;
   logic               y_tilt;

   // 17-bit difference never wraps; magnitude stays within 16 bits
   assign ax = 17'(raw_x) - 17'(cfg.offset_x);
   assign ay = 17'(raw_y) - 17'(cfg.offset_y);

   assign right  = ax[16];
   assign down   = ay[16];
   assign ax_abs = right ? (17'd0 - ax) : ax;
   assign ay_abs = down  ? (17'd0 - ay) : ay;
   assign mx     = ax_abs[15:0];
   assign my     = ay_abs[15:0];

   assign x_tilt = (mx >= cfg.enter_threshold);
   assign y_tilt = (my >= cfg.enter_threshold);

   always_comb begin
      priority if (!x_tilt && !y_tilt) begin
         verdict.dir = DIR_NONE;
      end else if (x_tilt && y_tilt) begin
         priority if (right && down) verdict.dir = DIR_DOWN_RIGHT;
         else if (right)             verdict.dir = DIR_UP_RIGHT;
         else if (down)              verdict.dir = DIR_DOWN_LEFT;
         else                        verdict.dir = DIR_UP_LEFT;
      end else if (mx >= my) begin
         verdict.dir = right ? DIR_RIGHT : DIR_LEFT;
      end else begin
         verdict.dir = down ? DIR_DOWN : DIR_UP;
      end
      verdict.release_hold = (mx < cfg.exit_threshold) && (my < cfg.exit_threshold);
   end

endmodule

// ===== tb/sv/tb.sv =====
// ----------------------------------------------------------------------------
// Tilt direction classifier core testbench
// Drives timestamped X/Y samples through the request channel under several
// register settings and idle patterns. A scoreboard keeps its own copy of the
// period gate, classifier, exit hysteresis and repeat countdown, and compares
// every response with the oldest predicted one.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
   import tdc_pkg::*;

   localparam int unsigned   CYCLE_LIMIT  = 200000;
   // Register slots past the last real one; writes there must change nothing.
   localparam csr_index_type CSR_SPARE_LO = 3'd6;
   localparam csr_index_type CSR_SPARE_HI = 3'd7;

   // Scoreboard: tracks gate, hold and repeat state, queues expected responses.
   class tilt_tracker;
      typedef struct {
         dir_type direction;
         logic    sampled;
      } report_type;

      logic [15:0]        enter_level;
      logic [15:0]        exit_level;
      logic [7:0]         repeat_reload;
      logic [15:0]        gap_ms;
      logic signed [15:0] bias_x;
      logic signed [15:0] bias_y;
      dir_type            held_dir;
      logic [7:0]         repeat_left;
      logic [31:0]        last_stamp;
      report_type         expected_reports[$];
      int unsigned        mismatches;

      function new();
         enter_level   = RST_ENTER_THRESHOLD;
         exit_level    = RST_EXIT_THRESHOLD;
         repeat_reload = RST_REPEAT_SAMPLES;
         gap_ms        = RST_SAMPLE_PERIOD_MS;
         bias_x        = '0;
         bias_y        = '0;
         held_dir      = DIR_NONE;
         repeat_left   = '0;
         last_stamp    = '0;
         mismatches    = 0;
      endfunction

      function void write_register(csr_index_type slot, logic [15:0] value);
         case (slot)
            CSR_ENTER_THRESHOLD:  enter_level   = value;
            CSR_EXIT_THRESHOLD:   exit_level    = value;
            CSR_REPEAT_SAMPLES:   repeat_reload = value[7:0];
            CSR_SAMPLE_PERIOD_MS: gap_ms        = value;
            CSR_OFFSET_X:         bias_x        = value;
            CSR_OFFSET_Y:         bias_y        = value;
            default: ;
         endcase
      endfunction

      function dir_type classify(int ax, int ay);
         int mx;
         int my;
         int enter_lvl;
         mx = (ax < 0) ? -ax : ax;
         my = (ay < 0) ? -ay : ay;
         enter_lvl = int'(enter_level);
         if (mx < enter_lvl && my < enter_lvl)
            return DIR_NONE;
         if (mx >= enter_lvl && my >= enter_lvl) begin
            if (ax < 0 && ay < 0)
               return DIR_DOWN_RIGHT;
            if (ax < 0)
               return DIR_UP_RIGHT;
            if (ay < 0)
               return DIR_DOWN_LEFT;
            return DIR_UP_LEFT;
         end
         // Larger axis wins, ties go to X.
         if (mx >= my) begin
            if (ax < 0)
               return DIR_RIGHT;
            return DIR_LEFT;
         end
         if (ay < 0)
            return DIR_DOWN;
         return DIR_UP;
      endfunction

      function void note_sample(logic [31:0] now, logic signed [15:0] raw_x,
                                logic signed [15:0] raw_y);
         report_type  rep;
         logic [31:0] elapsed;
         int          ax;
         int          ay;
         int          mx;
         int          my;
         int          exit_lvl;
         dir_type     dir;
         rep.direction = DIR_NONE;
         rep.sampled   = 1'b0;
         elapsed       = now - last_stamp;
         // A zero stamp means nothing accepted yet, so the gate stays open.
         if (last_stamp != '0 && elapsed < {16'd0, gap_ms}) begin
            expected_reports.push_back(rep);
            return;
         end
         rep.sampled = 1'b1;
         last_stamp  = now;
         ax  = int'(raw_x) - int'(bias_x);
         ay  = int'(raw_y) - int'(bias_y);
         mx  = (ax < 0) ? -ax : ax;
         my  = (ay < 0) ? -ay : ay;
         dir = classify(ax, ay);
         exit_lvl = int'(exit_level);
         if (mx < exit_lvl && my < exit_lvl) begin
            held_dir    = DIR_NONE;
            repeat_left = '0;
         end else if (dir != DIR_NONE) begin
            if (dir != held_dir) begin
               held_dir      = dir;
               repeat_left   = repeat_reload;
               rep.direction = dir;
            end else if (repeat_left != '0) begin
               repeat_left = repeat_left - 8'd1;
            end else begin
               repeat_left   = repeat_reload;
               rep.direction = dir;
            end
         end
         expected_reports.push_back(rep);
      endfunction

      function void check_report(logic [3:0] direction, logic sampled);
         report_type want;
         if (expected_reports.size() == 0) begin
            $error("unexpected response: direction %0d sampled %0b", direction, sampled);
            mismatches++;
            return;
         end
         want = expected_reports.pop_front();
         if (direction !== want.direction) begin
            $error("direction: expected %0d, got %0d", want.direction, direction);
            mismatches++;
         end
         if (sampled !== want.sampled) begin
            $error("sampled: expected %0b, got %0b", want.sampled, sampled);
            mismatches++;
         end
      endfunction
   endclass

   logic                  clock;
   logic                  reset;
   logic                  csr_we;
   csr_index_type         csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   tdc_req_if req_if();
   tdc_rsp_if rsp_if();

   tilt_tracker tracker = new();

   // Idle knobs, in percent per cycle, and the receiver's hold-off counter.
   int unsigned idle_pct;
   int unsigned stall_pct;
   int unsigned hold_off_left;
   int unsigned cycle_count;

   // Running sample clock and the last sample, reused to provoke repeats.
   logic [31:0]        clock_ms;
   logic signed [15:0] prev_x;
   logic signed [15:0] prev_y;
   logic               have_prev;

   tilt_direction_classifier_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_if),
      .rsp_ch    (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Receiver: stall at random, or hold off completely while the counter runs.
   initial begin
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_left > 0) begin
            rsp_if.ready <= 1'b0;
            hold_off_left = hold_off_left - 1;
         end else begin
            rsp_if.ready <= ($urandom_range(99) >= stall_pct);
         end
      end
   end

   // Monitor: note every accepted request, check every accepted response.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_if.valid && req_if.ready)
            tracker.note_sample(req_if.now_ms, req_if.raw_x, req_if.raw_y);
         if (rsp_if.valid && rsp_if.ready)
            tracker.check_report(rsp_if.direction, rsp_if.sampled);
      end
   end

   // Watchdog: end the run with a failure once the cycle limit is passed.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAIL tilt_direction_classifier_core");
         $finish;
      end
   end

   // Write one register; the caller drops csr_we after the last write of a batch.
   task automatic write_csr(csr_index_type slot, logic [15:0] value);
      csr_we    <= 1'b1;
      csr_index <= slot;
      csr_wdata <= value;
      @(posedge clock);
      tracker.write_register(slot, value);
   endtask

   // Load every register; also poke the unused slots, which must be ignored.
   task automatic apply_settings(logic [15:0] enter_lvl, logic [15:0] exit_lvl,
                                 logic [7:0] reload, logic [15:0] gap,
                                 logic [15:0] ofs_x, logic [15:0] ofs_y);
      write_csr(CSR_SPARE_LO, 16'($urandom()));
      write_csr(CSR_ENTER_THRESHOLD, enter_lvl);
      write_csr(CSR_EXIT_THRESHOLD, exit_lvl);
      write_csr(CSR_REPEAT_SAMPLES, {8'd0, reload});
      write_csr(CSR_SAMPLE_PERIOD_MS, gap);
      write_csr(CSR_OFFSET_X, ofs_x);
      write_csr(CSR_OFFSET_Y, ofs_y);
      write_csr(CSR_SPARE_HI, 16'hFFFF);
      csr_we <= 1'b0;
   endtask

   task automatic apply_random_settings();
      logic [15:0] enter_lvl;
      enter_lvl = 16'($urandom_range(9000, 300));
      apply_settings(enter_lvl, 16'($urandom_range(32'(enter_lvl) + 32'd2000)),
                     8'($urandom_range(6)), 16'($urandom_range(200)),
                     16'($urandom()), 16'($urandom()));
   endtask

   task automatic set_idling(int unsigned sender, int unsigned receiver);
      idle_pct  = sender;
      stall_pct = receiver;
   endtask

   // Offer one transaction and hold it until the block takes it.
   task automatic send_sample(logic [31:0] now, logic signed [15:0] x,
                              logic signed [15:0] y);
      while ($urandom_range(99) < idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid  <= 1'b1;
      req_if.now_ms <= now;
      req_if.raw_x  <= x;
      req_if.raw_y  <= y;
      @(posedge clock);
      while (!req_if.ready)
         @(posedge clock);
   endtask

   // Drop valid and wait until every predicted response has come back.
   task automatic drain();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (tracker.expected_reports.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Aim a magnitude at the current thresholds: below exit, between, above
   // enter, right on an edge, or anywhere.
   function automatic int pick_magnitude();
      int enter_lvl;
      int exit_lvl;
      int lo;
      int hi;
      int edges[5];
      enter_lvl = int'(tracker.enter_level);
      exit_lvl  = int'(tracker.exit_level);
      case ($urandom_range(4))
         0: begin
            if (exit_lvl == 0)
               return 0;
            return $urandom_range(exit_lvl - 1);
         end
         1: begin
            lo = (exit_lvl < enter_lvl) ? exit_lvl : enter_lvl;
            hi = (exit_lvl < enter_lvl) ? enter_lvl - 1 : exit_lvl - 1;
            if (hi < lo)
               hi = lo;
            return $urandom_range(hi, lo);
         end
         2: begin
            hi = enter_lvl + $urandom_range(3000);
            return (hi > 65535) ? 65535 : hi;
         end
         3: begin
            edges = '{exit_lvl - 1, exit_lvl, enter_lvl - 1, enter_lvl, 65535};
            lo = edges[$urandom_range(4)];
            return (lo < 0) ? 0 : lo;
         end
         default: return $urandom_range(65535);
      endcase
   endfunction

   // Turn a magnitude into a raw reading around the neutral offset; flip the
   // sign if that side does not fit in 16 bits.
   function automatic logic signed [15:0] place_axis(int mag, logic signed [15:0] ofs);
      int center;
      int v;
      center = int'(ofs);
      v = $urandom_range(1) ? center - mag : center + mag;
      if (v > 32767 || v < -32768)
         v = 2 * center - v;
      if (v > 32767)
         v = 32767;
      if (v < -32768)
         v = -32768;
      return v[15:0];
   endfunction

   task automatic run_random_items(int count);
      logic [31:0]        now;
      logic signed [15:0] x;
      logic signed [15:0] y;
      int unsigned        gap;
      int unsigned        pick;
      for (int i = 0; i < count; i++) begin
         gap  = 32'(tracker.gap_ms);
         pick = $urandom_range(99);
         // Mostly step past the period; sometimes too early, anywhere, or zero.
         if (pick < 8)
            now = $urandom();
         else if (pick < 11)
            now = '0;
         else if (pick < 26 && gap > 0)
            now = clock_ms + $urandom_range(gap - 1);
         else
            now = clock_ms + gap + $urandom_range(30);
         clock_ms = now;
         pick = $urandom_range(99);
         if (have_prev && pick < 35) begin
            x = prev_x;
            y = prev_y;
         end else if (pick < 45) begin
            x = 16'($urandom());
            y = 16'($urandom());
         end else begin
            x = place_axis(pick_magnitude(), tracker.bias_x);
            y = place_axis(pick_magnitude(), tracker.bias_y);
         end
         prev_x    = x;
         prev_y    = y;
         have_prev = 1'b1;
         send_sample(now, x, y);
      end
   endtask

   initial begin
      reset         <= 1'b1;
      csr_we        <= 1'b0;
      csr_index     <= CSR_ENTER_THRESHOLD;
      csr_wdata     <= '0;
      req_if.valid  <= 1'b0;
      req_if.now_ms <= '0;
      req_if.raw_x  <= '0;
      req_if.raw_y  <= '0;
      idle_pct      = 0;
      stall_pct     = 0;
      hold_off_left = 0;
      cycle_count   = 0;
      clock_ms      = '0;
      prev_x        = '0;
      prev_y        = '0;
      have_prev     = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: gate, every direction, release, repeat countdown, wrap.
      set_idling(0, 0);
      apply_settings(16'd4200, 16'd2200, 8'd2, 16'd50, 16'd0, 16'd0);
      send_sample(32'd0, 16'sd0, 16'sd0);              // accepted at time zero, release
      send_sample(32'd10, 16'sd5000, 16'sd0);          // zero stamp keeps the gate open
      send_sample(32'd20, 16'sd5000, 16'sd0);          // too soon: skipped
      send_sample(32'd60, 16'sd5000, 16'sd0);          // repeat suppressed
      send_sample(32'd110, 16'sd5000, 16'sd0);         // repeat suppressed
      send_sample(32'd160, 16'sd5000, 16'sd0);         // countdown spent: reported again
      send_sample(32'd210, -16'sd5000, 16'sd100);
      send_sample(32'd260, 16'sd100, -16'sd5000);
      send_sample(32'd310, 16'sd0, 16'sd5000);
      send_sample(32'd360, 16'sd5000, 16'sd5000);
      send_sample(32'd410, -16'sd5000, 16'sd5000);
      send_sample(32'd460, 16'sd5000, -16'sd5000);
      send_sample(32'd510, -16'sd5000, -16'sd5000);
      send_sample(32'd560, 16'sd3000, 16'sd3000);      // none, hold kept
      send_sample(32'd610, 16'sd1000, -16'sd1000);     // release
      send_sample(32'd660, 16'sd4200, 16'sd4199);      // enter threshold is inclusive
      send_sample(32'd710, 16'sh8000, 16'sd32767);
      send_sample(32'hFFFF_FFF0, 16'sd0, 16'sd5000);
      send_sample(32'h0000_000F, 16'sd0, 16'sd5000);   // wrapped difference too small
      send_sample(32'h0000_0022, 16'sd0, 16'sd5000);   // exactly one period: accepted
      send_sample(32'hFFFF_FFFF, 16'sd2199, -16'sd2199); // just under exit: release
      drain();

      // Reset values, no idling.
      apply_settings(RST_ENTER_THRESHOLD, RST_EXIT_THRESHOLD, RST_REPEAT_SAMPLES,
                     RST_SAMPLE_PERIOD_MS, 16'd0, 16'd0);
      run_random_items(54);
      drain();

      // Everything tilted, never released, longest countdown, no gate.
      set_idling(72, 0);
      apply_settings(16'd0, 16'd0, 8'd255, 16'd0, 16'd0, 16'd0);
      run_random_items(54);
      drain();

      // Top thresholds, longest period, opposite extreme offsets.
      set_idling(0, 72);
      apply_settings(16'hFFFF, 16'hFFFF, 8'd1, 16'hFFFF, 16'h7FFF, 16'h8000);
      run_random_items(54);
      drain();

      // Exit above enter: tilted samples can still release.
      set_idling(19, 19);
      apply_settings(16'd3000, 16'd5000, 8'd3, 16'd20, 16'($urandom()), 16'($urandom()));
      run_random_items(54);
      drain();

      // Back-pressure: hold the receiver off so the block fills and stalls its
      // input, then pause the sender until everything is back.
      set_idling(0, 0);
      apply_settings(16'd1000, 16'd500, 8'd5, 16'd1, 16'h8000, 16'h7FFF);
      hold_off_left = 80;
      run_random_items(27);
      drain();
      run_random_items(27);
      drain();

      // Random settings under each idle pattern.
      set_idling(72, 0);
      apply_random_settings();
      run_random_items(54);
      drain();

      set_idling(0, 72);
      apply_random_settings();
      run_random_items(54);
      drain();

      set_idling(19, 19);
      apply_random_settings();
      run_random_items(54);
      drain();

      repeat (10) @(posedge clock);
      if (tracker.mismatches == 0 && tracker.expected_reports.size() == 0) begin
         $display("PASS tilt_direction_classifier_core");
      end else begin
         $display("FAIL tilt_direction_classifier_core");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+sv
sv/tdc_pkg.sv
sv/tdc_if.sv
sv/tdc_classify.sv
sv/tilt_direction_classifier_core.sv
tb/sv/tb.sv
